// File: rtl/core/crst_pkg.sv
// Shared types, widths and codes for the midpoint circle rasterizer.
package crst_pkg;

  localparam int COORD_W     = 16;
  localparam int RAD_W       = 12;
  localparam int STEP_W      = 13;
  localparam int DEC_W       = 18;
  localparam int PT_W        = 18;
  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 24;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int POINTS      = 8;
  localparam int PT_IDX_W    = $clog2(POINTS);
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [STEP_W-1:0]  a;
    logic signed [STEP_W-1:0]  b;
    logic [COLOR_W-1:0]        color;
    logic                      fin;
    logic                      nop;
  } job_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
  } surf_cfg_t;

endpackage

// File: rtl/core/midpoint_circle_raster.sv
// Top level of the midpoint circle rasterizer with surface configuration registers.
//
// Requests enter on the in_ channel: a start request (cmd 0) latches center, radius
// and color and produces the eight mirrored points of (0, radius); a step request
// (cmd 1) advances the decision recurrence by one column and produces eight points.
// A step with no circle in progress produces a single empty point with last and
// done_res set. Each point leaves on the out_ channel as one request, with
// write_enable low and address and value zero when it falls outside the surface.
// The cfg_ channel writes surface width (index 0) and height (index 1); it is always
// ready. The user must see that it is written only while the block is idle; the
// block itself does not enforce this. A point passes the queue entry, then the a_
// stage and out_ registers. The single output port emits one point per cycle while
// out_ready is high. A two-entry job queue lets the next request be accepted while
// points of earlier ones are still leaving. When out_ready is low the whole point
// pipeline holds and the queue fills, then in_ready drops. Reset clears all control
// state, sets width 640 and height 480, and leaves no circle in progress.
module midpoint_circle_raster #(
  parameter int MAX_WIDTH  = crst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = crst_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_y,
  input  logic [crst_pkg::RAD_W-1:0]          in_radius,
  input  logic [crst_pkg::COLOR_W-1:0]        in_paint_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crst_pkg::ADDR_W-1:0]         out_pixel_address,
  output logic [crst_pkg::COLOR_W-1:0]        out_pixel_value,
  output logic                                out_write_enable,
  output logic                                out_last,
  output logic                                out_done_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crst_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import crst_pkg::*;

  logic [CFG_DATA_W-1:0] surface_width_r, surface_width_nxt;
  logic [CFG_DATA_W-1:0] surface_height_r, surface_height_nxt;
  surf_cfg_t             surf_cfg;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  job_t                  push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    surface_width_nxt  = surface_width_r;
    surface_height_nxt = surface_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width_nxt  = cfg_data;
        REG_SURFACE_HEIGHT: surface_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= RESET_WIDTH;
      surface_height_r <= RESET_HEIGHT;
    end else begin
      surface_width_r  <= surface_width_nxt;
      surface_height_r <= surface_height_nxt;
    end
  end

  assign surf_cfg.width  = surface_width_r;
  assign surf_cfg.height = surface_height_r;

  crst_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_paint_color (in_paint_color),
    .q_valid        (push_valid),
    .q_ready        (push_ready),
    .q_data         (push_data)
  );

  crst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  crst_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .surf_cfg          (surf_cfg),
    .q_valid           (pop_valid),
    .q_ready           (pop_ready),
    .q_data            (pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_enable  (out_write_enable),
    .out_last          (out_last),
    .out_done_res      (out_done_res)
  );

endmodule

// File: rtl/core/crst_front.sv
// Front end: accepts commands, runs the circle decision recurrence and queues octant jobs.
module crst_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_y,
  input  logic [crst_pkg::RAD_W-1:0]   in_radius,
  input  logic [crst_pkg::COLOR_W-1:0] in_paint_color,
  output logic                         q_valid,
  input  logic                         q_ready,
  output crst_pkg::job_t               q_data
);
  import crst_pkg::*;

  logic signed [STEP_W-1:0]  cur_x_r, cur_x_nxt;
  logic signed [STEP_W-1:0]  cur_y_r, cur_y_nxt;
  logic signed [DEC_W-1:0]   decision_r, decision_nxt;
  logic signed [COORD_W-1:0] saved_cx_r, saved_cx_nxt;
  logic signed [COORD_W-1:0] saved_cy_r, saved_cy_nxt;
  logic [COLOR_W-1:0]        saved_color_r, saved_color_nxt;
  logic                      active_r, active_nxt;

  logic                      accept;
  logic signed [STEP_W-1:0]  x_inc, y_dec, rad_s, y_new;
  logic signed [DEC_W-1:0]   x_ext, y_ext, step_add;
  logic                      finish;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    decision_nxt    = decision_r;
    saved_cx_nxt    = saved_cx_r;
    saved_cy_nxt    = saved_cy_r;
    saved_color_nxt = saved_color_r;
    active_nxt      = active_r;

    x_inc  = cur_x_r + STEP_W'(1);
    y_dec  = cur_y_r - STEP_W'(1);
    rad_s  = {1'b0, in_radius};
    y_new  = decision_r[DEC_W-1] ? cur_y_r : y_dec;
    x_ext  = {{(DEC_W-STEP_W){x_inc[STEP_W-1]}}, x_inc};
    y_ext  = {{(DEC_W-STEP_W){y_new[STEP_W-1]}}, y_new};
    if (decision_r[DEC_W-1]) begin
      step_add = (x_ext <<< 2) + DEC_W'(6);
    end else begin
      step_add = ((x_ext - y_ext) <<< 2) + DEC_W'(10);
    end
    finish = y_new < x_inc;

    q_data.cx    = saved_cx_r;
    q_data.cy    = saved_cy_r;
    q_data.a     = x_inc;
    q_data.b     = y_new;
    q_data.color = saved_color_r;
    q_data.fin   = finish;
    q_data.nop   = 1'b0;

    if (in_cmd == CMD_START) begin
      q_data.cx    = in_center_x;
      q_data.cy    = in_center_y;
      q_data.a     = '0;
      q_data.b     = rad_s;
      q_data.color = in_paint_color;
      q_data.fin   = 1'b0;
      if (accept) begin
        saved_cx_nxt    = in_center_x;
        saved_cy_nxt    = in_center_y;
        saved_color_nxt = in_paint_color;
        cur_x_nxt       = '0;
        cur_y_nxt       = rad_s;
        decision_nxt    = DEC_W'(3) - (DEC_W'(in_radius) <<< 1);
        active_nxt      = 1'b1;
      end
    end else if (!active_r) begin
      q_data.nop = 1'b1;
      q_data.fin = 1'b1;
    end else if (accept) begin
      cur_x_nxt    = x_inc;
      cur_y_nxt    = y_new;
      decision_nxt = decision_r + step_add;
      active_nxt   = !finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      decision_r    <= '0;
      saved_cx_r    <= '0;
      saved_cy_r    <= '0;
      saved_color_r <= '0;
      active_r      <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      decision_r    <= decision_nxt;
      saved_cx_r    <= saved_cx_nxt;
      saved_cy_r    <= saved_cy_nxt;
      saved_color_r <= saved_color_nxt;
      active_r      <= active_nxt;
    end
  end

endmodule

// File: rtl/core/crst_queue.sv
// Short job queue that decouples the front end from the point emitter.
module crst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  crst_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output crst_pkg::job_t pop_data
);
  import crst_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t               entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/crst_back.sv
// Back end: walks the eight mirrored points of a job, clips them and forms addresses.
module crst_back #(
  parameter int MAX_WIDTH  = crst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = crst_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crst_pkg::surf_cfg_t           surf_cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  crst_pkg::job_t                q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crst_pkg::ADDR_W-1:0]   out_pixel_address,
  output logic [crst_pkg::COLOR_W-1:0]  out_pixel_value,
  output logic                          out_write_enable,
  output logic                          out_last,
  output logic                          out_done_res
);
  import crst_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W = (WW + HW + 1 > ADDR_W) ? WW + HW + 1 : ADDR_W;

  logic [WW-1:0]          w_eff;
  logic [HW-1:0]          h_eff;
  logic [PT_W-1:0]        w_ext, h_ext;

  logic [PT_IDX_W-1:0]    k_r, k_nxt;
  logic                   adv, take, last_pt, swap;
  logic signed [PT_W-1:0] cx_ext, cy_ext, a_ext, b_ext, dx, dy, px, py;
  logic                   in_bounds;

  logic                   a_valid_r;
  logic [WW-1:0]          a_px_r;
  logic [HW-1:0]          a_py_r;
  logic                   a_inside_r, a_last_r, a_fin_r;
  logic [COLOR_W-1:0]     a_color_r;

  logic [SUM_W-1:0]       addr_sum;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [COLOR_W-1:0]     out_value_r;
  logic                   out_we_r, out_last_r, out_done_r;

  always_comb begin
    if (32'(surf_cfg.width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(surf_cfg.width);
    end
    if (32'(surf_cfg.height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(surf_cfg.height);
    end
  end

  assign w_ext = PT_W'(w_eff);
  assign h_ext = PT_W'(h_eff);

  assign adv     = !out_valid_r || out_ready;
  assign take    = adv && q_valid;
  assign last_pt = q_data.nop || (k_r == PT_IDX_W'(POINTS - 1));
  assign q_ready = adv && last_pt;

  always_comb begin
    k_nxt = k_r;
    if (take) begin
      k_nxt = last_pt ? '0 : k_r + PT_IDX_W'(1);
    end
  end

  always_comb begin
    cx_ext = {{(PT_W-COORD_W){q_data.cx[COORD_W-1]}}, q_data.cx};
    cy_ext = {{(PT_W-COORD_W){q_data.cy[COORD_W-1]}}, q_data.cy};
    a_ext  = {{(PT_W-STEP_W){q_data.a[STEP_W-1]}}, q_data.a};
    b_ext  = {{(PT_W-STEP_W){q_data.b[STEP_W-1]}}, q_data.b};
    swap   = k_r[2] ^ k_r[1];
    dx     = swap ? b_ext : a_ext;
    dy     = swap ? a_ext : b_ext;
    px     = k_r[0] ? cx_ext + dx : cx_ext - dx;
    py     = k_r[2] ? cy_ext + dy : cy_ext - dy;
    in_bounds = !px[PT_W-1] && (px != '0) && (px < w_ext)
             && !py[PT_W-1] && (py != '0) && (py < h_ext) && !q_data.nop;
  end

  assign addr_sum = SUM_W'(a_py_r) * SUM_W'(w_eff) + SUM_W'(a_px_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (adv) begin
        a_valid_r   <= q_valid;
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_r     <= WW'(px);
      a_py_r     <= HW'(py);
      a_inside_r <= in_bounds;
      a_last_r   <= last_pt;
      a_fin_r    <= q_data.fin;
      a_color_r  <= q_data.color;
      out_addr_r  <= a_inside_r ? addr_sum[ADDR_W-1:0] : '0;
      out_value_r <= a_inside_r ? a_color_r : '0;
      out_we_r    <= a_inside_r;
      out_last_r  <= a_last_r;
      out_done_r  <= a_fin_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_value   = out_value_r;
  assign out_write_enable  = out_we_r;
  assign out_last          = out_last_r;
  assign out_done_res      = out_done_r;

endmodule

// File: verif/circle_pixel_checker.sv
// Checker that predicts and compares the pixel writes of the midpoint circle rasterizer.
`timescale 1ns / 1ps

module circle_pixel_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [crst_pkg::COORD_W-1:0] in_center_y,
  input  logic [crst_pkg::RAD_W-1:0]          in_radius,
  input  logic [crst_pkg::COLOR_W-1:0]        in_paint_color,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [crst_pkg::ADDR_W-1:0]         out_pixel_address,
  input  logic [crst_pkg::COLOR_W-1:0]        out_pixel_value,
  input  logic                                out_write_enable,
  input  logic                                out_last,
  input  logic                                out_done_res,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [crst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crst_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import crst_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] value;
    logic               we;
    logic               last;
    logic               done;
  } pixel_t;

  logic [CFG_DATA_W-1:0]     surf_w;
  logic [CFG_DATA_W-1:0]     surf_h;
  logic signed [STEP_W-1:0]  ring_x;
  logic signed [STEP_W-1:0]  ring_y;
  logic signed [DEC_W-1:0]   ring_err;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic [COLOR_W-1:0]        ink;
  logic                      tracing;
  pixel_t                    pixel_q[$];
  pixel_t                    want;

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $time, field, got, exp_v);
    errors++;
  endtask

  function automatic pixel_t clip_pixel(input int px, input int py, input logic is_last,
                                        input logic fin);
    int     w;
    int     h;
    pixel_t p;
    w = (surf_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(surf_w);
    h = (surf_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(surf_h);
    p = '0;
    p.last = is_last;
    p.done = fin;
    if (px > 0 && px < w && py > 0 && py < h) begin
      p.addr  = ADDR_W'(py * w + px);
      p.value = ink;
      p.we    = 1'b1;
    end
    return p;
  endfunction

  task automatic push_octants(input logic fin);
    int cx;
    int cy;
    int a;
    int b;
    cx = int'(org_x);
    cy = int'(org_y);
    a  = int'(ring_x);
    b  = int'(ring_y);
    pixel_q.push_back(clip_pixel(cx - a, cy - b, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx + a, cy - b, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx - b, cy - a, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx + b, cy - a, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx - b, cy + a, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx + b, cy + a, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx - a, cy + b, 1'b0, fin));
    pixel_q.push_back(clip_pixel(cx + a, cy + b, 1'b1, fin));
  endtask

  task automatic trace_request(input logic cmd, input logic signed [COORD_W-1:0] cx,
                               input logic signed [COORD_W-1:0] cy,
                               input logic [RAD_W-1:0] r, input logic [COLOR_W-1:0] color);
    int     nx;
    int     ny;
    int     nerr;
    pixel_t blank;
    if (cmd == CMD_START) begin
      org_x    = cx;
      org_y    = cy;
      ink      = color;
      ring_x   = '0;
      ring_y   = STEP_W'(int'(r));
      ring_err = DEC_W'(3 - 2 * int'(r));
      tracing  = 1'b1;
      push_octants(1'b0);
    end else if (!tracing) begin
      blank      = '0;
      blank.last = 1'b1;
      blank.done = 1'b1;
      pixel_q.push_back(blank);
    end else begin
      nx   = int'(ring_x) + 1;
      ny   = int'(ring_y);
      nerr = int'(ring_err);
      if (nerr >= 0) begin
        ny   = ny - 1;
        nerr = nerr + 4 * (nx - ny) + 10;
      end else begin
        nerr = nerr + 4 * nx + 6;
      end
      ring_x   = STEP_W'(nx);
      ring_y   = STEP_W'(ny);
      ring_err = DEC_W'(nerr);
      if (ny < nx) begin
        tracing = 1'b0;
      end
      push_octants(!tracing);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      surf_w   = RESET_WIDTH;
      surf_h   = RESET_HEIGHT;
      ring_x   = '0;
      ring_y   = '0;
      ring_err = '0;
      org_x    = '0;
      org_y    = '0;
      ink      = '0;
      tracing  = 1'b0;
      pixel_q.delete();
      errors   = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SURFACE_WIDTH) begin
          surf_w = cfg_data;
        end else begin
          surf_h = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected point", 32'(out_pixel_address), '0);
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_address !== want.addr) begin
            report("pixel_address", 32'(out_pixel_address), 32'(want.addr));
          end
          if (out_pixel_value !== want.value) begin
            report("pixel_value", out_pixel_value, want.value);
          end
          if (out_write_enable !== want.we) begin
            report("write_enable", 32'(out_write_enable), 32'(want.we));
          end
          if (out_last !== want.last) begin
            report("last", 32'(out_last), 32'(want.last));
          end
          if (out_done_res !== want.done) begin
            report("done_res", 32'(out_done_res), 32'(want.done));
          end
        end
      end
      if (in_valid && in_ready) begin
        trace_request(in_cmd, in_center_x, in_center_y, in_radius, in_paint_color);
      end
      pending <= pixel_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the midpoint circle rasterizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import crst_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_cmd;
  logic signed [COORD_W-1:0]   in_center_x;
  logic signed [COORD_W-1:0]   in_center_y;
  logic [RAD_W-1:0]            in_radius;
  logic [COLOR_W-1:0]          in_paint_color;
  logic                        out_valid;
  logic                        out_ready;
  logic [ADDR_W-1:0]           out_pixel_address;
  logic [COLOR_W-1:0]          out_pixel_value;
  logic                        out_write_enable;
  logic                        out_last;
  logic                        out_done_res;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  int                          errors;
  int                          pending;
  bit                          calm;
  bit                          hold_ask;
  int                          sent;

  midpoint_circle_raster i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_radius         (in_radius),
    .in_paint_color    (in_paint_color),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_enable  (out_write_enable),
    .out_last          (out_last),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  circle_pixel_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_radius         (in_radius),
    .in_paint_color    (in_paint_color),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_enable  (out_write_enable),
    .out_last          (out_last),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .errors            (errors),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** midpoint_circle_raster: FAILED **");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [COORD_W-1:0] cx,
                           input logic [COORD_W-1:0] cy, input logic [RAD_W-1:0] r,
                           input logic [COLOR_W-1:0] color);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_radius      <= r;
    in_paint_color <= color;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic step_n(input int n);
    repeat (n) begin
      send_item(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom),
                $urandom);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_surface(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SURFACE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int quota, input int w, input int h);
    int start_at;
    int r;
    int cx;
    int cy;
    start_at = sent;
    while (sent - start_at < quota) begin
      case ($urandom_range(0, 9))
        0: begin
          step_n(1);
        end
        1: begin
          send_item(CMD_START, COORD_W'($urandom), COORD_W'($urandom),
                    RAD_W'($urandom_range(0, 4095)), $urandom);
          step_n(int'($urandom_range(0, 6)));
        end
        default: begin
          r  = int'($urandom_range(0, 24));
          cx = int'($urandom_range(0, w + 2 * r)) - r;
          cy = int'($urandom_range(0, h + 2 * r)) - r;
          send_item(CMD_START, COORD_W'(cx), COORD_W'(cy), RAD_W'(r), $urandom);
          step_n(int'($urandom_range(0, r * 3 / 4 + 3)));
        end
      endcase
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_cmd         <= CMD_START;
    in_center_x    <= '0;
    in_center_y    <= '0;
    in_radius      <= '0;
    in_paint_color <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_SURFACE_WIDTH;
    cfg_data       <= '0;
    calm     = 1'b0;
    hold_ask = 1'b0;
    sent     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A step with no circle in progress, then a full small circle past its end.
    step_n(1);
    send_item(CMD_START, 16'sd100, 16'sd100, 12'd5, 32'hA5A5_5A5A);
    step_n(5);
    // Zero radius, and a circle that touches the excluded row and column zero.
    send_item(CMD_START, 16'sd10, 16'sd10, 12'd0, 32'h0000_0001);
    step_n(2);
    send_item(CMD_START, 16'sd0, 16'sd0, 12'd1, 32'h8000_0000);
    step_n(2);
    send_item(CMD_START, 16'h8000, 16'h7FFF, 12'hFFF, 32'hFFFF_FFFF);
    step_n(1);
    send_item(CMD_START, 16'h7FFF, 16'h8000, 12'd0, 32'h0000_0000);
    step_n(1);

    set_surface(13'd4096, 13'd4096);
    send_item(CMD_START, 16'sd2048, 16'sd2048, 12'hFFF, 32'h1234_5678);
    step_n(2);
    set_surface(13'd0, 13'd0);
    send_item(CMD_START, 16'sd5, 16'sd5, 12'd3, 32'hDEAD_BEEF);
    step_n(1);
    set_surface(13'h1FFF, 13'h1FFF);
    send_item(CMD_START, 16'sd4000, 16'sd4000, 12'd200, 32'hCAFE_F00D);
    step_n(1);

    set_surface(13'd640, 13'd480);
    hold_ask = 1'b1;
    random_traffic(80, 640, 480);
    set_surface(13'd1, 13'd1);
    random_traffic(40, 4, 4);
    set_surface(13'd4096, 13'd4096);
    random_traffic(80, 4096, 4096);
    set_surface(13'd300, 13'h1FFF);
    random_traffic(70, 300, 4096);
    set_surface(13'h1FFF, 13'd200);
    random_traffic(70, 4096, 200);
    set_surface(CFG_DATA_W'($urandom_range(1, 4096)), CFG_DATA_W'($urandom_range(1, 4096)));
    calm = 1'b1;
    random_traffic(80, 512, 512);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("** midpoint_circle_raster: PASSED **");
    end else begin
      $display("** midpoint_circle_raster: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/crst_pkg.sv
rtl/core/crst_front.sv
rtl/core/crst_queue.sv
rtl/core/crst_back.sv
rtl/core/midpoint_circle_raster.sv
verif/circle_pixel_checker.sv
verif/testbench.sv
